>>> sv/fusc_pkg.sv
`timescale 1ns / 1ps
package fusc_pkg;

  localparam int PAGE_BYTES        = 64;
  localparam int PAGE_BITS         = $clog2(PAGE_BYTES);
  localparam int RESET_VECTOR_WORD = 0;

  localparam logic [15:0] VEC_ADDR      = 16'(RESET_VECTOR_WORD * 2);
  localparam logic [15:0] VEC_ADDR_NEXT = 16'(RESET_VECTOR_WORD * 2 + 2);
  localparam logic [15:0] PAGE_MASK     = ~16'(PAGE_BYTES - 1);
  localparam logic [15:0] RJMP_BASE     = 16'hC000;
  localparam logic [15:0] JMP_OPCODE    = 16'h940C;
  localparam logic [15:0] RJMP_LIMIT    = 16'd8192;

  // result actions
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_INFO  = 3'd1;
  localparam logic [2:0] ACT_CLEAR = 3'd2;
  localparam logic [2:0] ACT_FILL  = 3'd3;
  localparam logic [2:0] ACT_WRITE = 3'd4;
  localparam logic [2:0] ACT_ERASE = 3'd5;
  localparam logic [2:0] ACT_LEAVE = 3'd6;

  // pending commands
  localparam logic [6:0] PEND_NONE  = 7'd0;
  localparam logic [6:0] PEND_ERASE = 7'd2;
  localparam logic [6:0] PEND_EXIT  = 7'd4;
  localparam logic [6:0] PEND_WRITE = 7'd64;

  // request codes
  localparam logic [7:0] REQ_INFO     = 8'd0;
  localparam logic [7:0] REQ_SET_ADDR = 8'd1;
  localparam logic [7:0] REQ_DATA     = 8'd3;

  localparam logic OP_SETUP = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic CFG_BOOT_ADDR = 1'b0;
  localparam logic CFG_AUTO_EXIT = 1'b1;

  localparam logic [15:0] BOOT_ADDR_RST = 16'd6144;
  localparam logic [15:0] AUTO_EXIT_RST = 16'd1200;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic       op;
    logic [7:0] request_code;
    logic [15:0] value_word;
    logic [15:0] index_word;
    logic       timed_out;
    logic       app_present;
  } item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] flash_address;
    logic [15:0] flash_data;
    logic        last;
  } result_t;

  // up to two result beats produced by one accepted item
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

>>> sv/flash_upload_command_sequencer_core.sv
`timescale 1ns / 1ps
// Upload command sequencer for a flash bootloader.
// Input stream (in_*): one beat per host setup request or main-loop poll tick;
// in_tuser carries the kind (0 setup, 1 tick). Result stream (out_*): one or
// two beats per input beat, the action in out_tuser, out_tlast on the final
// beat of each input. Data requests give two fill beats, ticks may give an
// erase or page write followed by a leave, everything else gives one beat.
// Configuration (cfg_*): boot address (index 0) and auto-exit poll count
// (index 1); cfg_ready is always high, write only while the block is idle.
// Results are registered: the beats of an accepted item are written into a
// four-entry queue, whose head drives out_*. Throughput: one input beat per
// cycle while each item gives one result beat and out_tready is high; an item
// with two beats sends them one after the other through the single result port.
// in_tready is high while the queue has at least two free entries, independent of
// out_tready, so a stalled receiver holds its beats in the queue and the input
// side keeps going until fewer than two entries are free.
// Reset clears the write address, pending command, idle count and the queue,
// and loads the boot address with 6144 and the auto-exit count with 1200.
module flash_upload_command_sequencer_core
  import fusc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // request_code, value_word, index_word,
                                  // timed_out, app_present, zero pad
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // flash_address, flash_data
  output logic [2:0]  out_tuser,  // action
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  item_t   item;
  push_t   push;
  result_t head;
  logic    in_accept;
  logic    room;

  assign item.op           = in_tuser;
  assign item.request_code = in_tdata[7:0];
  assign item.value_word   = in_tdata[23:8];
  assign item.index_word   = in_tdata[39:24];
  assign item.timed_out    = in_tdata[40];
  assign item.app_present  = in_tdata[41];

  assign in_tready = room;
  assign in_accept = in_tvalid && room;
  assign cfg_ready = 1'b1;

  fusc_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (in_accept),
    .item       (item),
    .push       (push)
  );

  fusc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .head_valid (out_tvalid),
    .head       (head),
    .pop        (out_tready)
  );

  assign out_tdata = {head.flash_data, head.flash_address};
  assign out_tuser = head.action;
  assign out_tlast = head.last;

endmodule

>>> sv/fusc_seq.sv
`timescale 1ns / 1ps
module fusc_seq
  import fusc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  input  item_t       item,
  output push_t       push
);

  logic [15:0] boot_address_r, boot_address_nxt;
  logic [15:0] auto_exit_r, auto_exit_nxt;
  logic [15:0] write_address_r, write_address_nxt;
  logic [6:0]  pending_r, pending_nxt;
  logic [15:0] idle_count_r, idle_count_nxt;

  logic [15:0] wa_plus2;
  logic [15:0] wa_plus4;
  logic [15:0] wa_minus2;
  logic [15:0] idle_inc;
  logic [15:0] set_addr;
  logic        leave;
  logic        primary;
  result_t     r_primary;
  result_t     r_leave;

  function automatic logic [15:0] patch_word(input logic [15:0] addr,
                                             input logic [15:0] boot,
                                             input logic [15:0] data);
    logic [15:0] w;
    w = data;
    if (boot < RJMP_LIMIT) begin
      if (addr == VEC_ADDR) begin
        w = RJMP_BASE + {1'b0, boot[15:1]} - 16'd1;
      end
    end else begin
      if (addr == VEC_ADDR) begin
        w = JMP_OPCODE;
      end else if (addr == VEC_ADDR_NEXT) begin
        w = {1'b0, boot[15:1]};
      end
    end
    return w;
  endfunction

  always_comb begin
    boot_address_nxt = boot_address_r;
    auto_exit_nxt    = auto_exit_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOOT_ADDR: boot_address_nxt = cfg_data;
        CFG_AUTO_EXIT: auto_exit_nxt    = cfg_data;
        default:       boot_address_nxt = boot_address_r;
      endcase
    end
  end

  always_comb begin
    write_address_nxt = write_address_r;
    pending_nxt       = pending_r;
    idle_count_nxt    = idle_count_r;
    wa_plus2          = write_address_r + 16'd2;
    wa_plus4          = write_address_r + 16'd4;
    wa_minus2         = write_address_r - 16'd2;
    idle_inc          = idle_count_r + 16'd1;
    set_addr          = item.index_word & PAGE_MASK;
    leave             = 1'b0;
    primary           = 1'b0;
    r_primary         = '0;
    r_leave           = '0;
    r_leave.action    = ACT_LEAVE;
    push              = '0;

    if (item.op == OP_SETUP) begin
      idle_count_nxt = {8'd0, idle_count_r[7:0]};
      unique case (item.request_code)
        REQ_INFO: begin
          push.count        = 2'd1;
          push.first.action = ACT_INFO;
        end
        REQ_SET_ADDR: begin
          // ignored while the write address is zero (after reset or an erase)
          if (write_address_r != 16'd0) begin
            write_address_nxt        = set_addr;
            push.count               = 2'd1;
            push.first.action        = ACT_CLEAR;
            push.first.flash_address = set_addr;
          end
        end
        REQ_DATA: begin
          write_address_nxt         = wa_plus4;
          push.count                = 2'd2;
          push.first.action         = ACT_FILL;
          push.first.flash_address  = write_address_r;
          push.first.flash_data     = patch_word(write_address_r, boot_address_r,
                                                 item.value_word);
          push.second.action        = ACT_FILL;
          push.second.flash_address = wa_plus2;
          push.second.flash_data    = patch_word(wa_plus2, boot_address_r,
                                                 item.index_word);
          if (wa_plus4[PAGE_BITS-1:0] == '0) begin
            pending_nxt = PEND_WRITE;
          end
        end
        default: pending_nxt = item.request_code[5:0] == 6'd0 ? PEND_NONE
                                                               : {1'b0, item.request_code[5:0]};
      endcase
    end else begin
      if (pending_r == PEND_ERASE) begin
        primary           = 1'b1;
        r_primary.action  = ACT_ERASE;
        write_address_nxt = 16'd0;
      end
      if (pending_r == PEND_WRITE && wa_minus2 < boot_address_r) begin
        primary                 = 1'b1;
        r_primary.action        = ACT_WRITE;
        r_primary.flash_address = wa_minus2;
      end
      if (pending_r == PEND_EXIT) begin
        leave = item.timed_out;
      end else begin
        pending_nxt = PEND_NONE;
      end
      if (!leave) begin
        idle_count_nxt = idle_inc;
        if (auto_exit_r != 16'd0 && idle_inc == auto_exit_r && item.app_present) begin
          leave = 1'b1;
        end
      end
      if (primary && leave) begin
        push.count  = 2'd2;
        push.first  = r_primary;
        push.second = r_leave;
      end else if (primary) begin
        push.count = 2'd1;
        push.first = r_primary;
      end else if (leave) begin
        push.count = 2'd1;
        push.first = r_leave;
      end
    end

    // nothing to report: a single empty beat
    if (push.count == 2'd0) begin
      push.count        = 2'd1;
      push.first.action = ACT_NONE;
    end
    if (push.count == 2'd2) begin
      push.second.last = 1'b1;
    end else begin
      push.first.last = 1'b1;
    end
    if (!item_valid) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boot_address_r  <= BOOT_ADDR_RST;
      auto_exit_r     <= AUTO_EXIT_RST;
      write_address_r <= '0;
      pending_r       <= PEND_NONE;
      idle_count_r    <= '0;
    end else begin
      boot_address_r <= boot_address_nxt;
      auto_exit_r    <= auto_exit_nxt;
      if (item_valid) begin
        write_address_r <= write_address_nxt;
        pending_r       <= pending_nxt;
        idle_count_r    <= idle_count_nxt;
      end
    end
  end

  a_erase_clears_addr: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && item.op == OP_TICK && pending_r == PEND_ERASE
    |=> write_address_r == 16'd0)
    else $error("erase tick did not clear write address");

  a_pending_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && item.op == OP_TICK && pending_r != PEND_EXIT
    |=> pending_r == PEND_NONE)
    else $error("tick left a stale pending command");

  a_fill_pair: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && item.op == OP_SETUP && item.request_code == REQ_DATA
    |-> push.count == 2'd2 && push.second.flash_address == push.first.flash_address + 16'd2)
    else $error("data request did not give two consecutive fill beats");

endmodule

>>> sv/fusc_queue.sv
`timescale 1ns / 1ps
module fusc_queue
  import fusc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    room,
  output logic    head_valid,
  output result_t head,
  input  logic    pop
);

  result_t                 mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0]  count_r, count_nxt;
  logic [QUEUE_PTR_W-1:0]  wr_ptr_plus1;
  logic                    do_pop;

  assign wr_ptr_plus1 = wr_ptr_r + 1'b1;
  assign head_valid   = count_r != '0;
  assign head         = mem[rd_ptr_r];
  assign do_pop       = pop && head_valid;
  // two free slots cover the largest burst of one item
  assign room         = count_r <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QUEUE_PTR_W'(push.count);
    rd_ptr_nxt = rd_ptr_r + QUEUE_PTR_W'(do_pop);
    count_nxt  = count_r + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_plus1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.count != 2'd0 |-> room)
    else $error("result queue written without room");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("result queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    QUEUE_PTR_W'(wr_ptr_r - rd_ptr_r) == QUEUE_PTR_W'(count_r))
    else $error("result queue pointers disagree with count");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top
  import fusc_pkg::*;
();

  localparam logic [7:0] REQ_ERASE = 8'd2;
  localparam logic [7:0] REQ_EXIT  = 8'd4;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         NUM_PHASES  = 8;
  localparam int         PHASE_ITEMS = 220;

  typedef struct packed {
    item_t   it;
    logic    pinned;
    result_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // request_code, value_word, index_word,
                                // timed_out, app_present, zero pad
  logic        in_tuser = 1'b0; // op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // flash_address, flash_data
  logic [2:0]  out_tuser;       // action
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  // expectation typed into a directed row, travels with its input beat
  logic        pin_on = 1'b0;
  result_t     pin_beat = '0;

  // predictor state and configuration copy
  logic [15:0] wr_addr = '0;
  logic [6:0]  pend_cmd = PEND_NONE;
  logic [15:0] idle_cnt = '0;
  logic [15:0] boot_q = BOOT_ADDR_RST;
  logic [15:0] auto_q = AUTO_EXIT_RST;

  result_t     owed_actions[$];
  row_t        directed_rows[$];

  int          errors = 0;
  int          sent = 0;
  int          checked = 0;
  int          cycles = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          act_seen[8];

  flash_upload_command_sequencer_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still owed", cycles,
               owed_actions.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    if (errors < 40)
      $display("mismatch at result %0d: %s got %h want %h", checked, what, got, want);
    errors++;
  endtask

  function automatic item_t mk(input logic op, input logic [7:0] code,
                               input logic [15:0] vw, input logic [15:0] iw,
                               input logic tmo, input logic app);
    item_t it;
    it.op = op;
    it.request_code = code;
    it.value_word = vw;
    it.index_word = iw;
    it.timed_out = tmo;
    it.app_present = app;
    return it;
  endfunction

  function automatic result_t beat(input logic [2:0] act, input logic [15:0] addr,
                                   input logic [15:0] data, input logic lst);
    result_t r;
    r.action = act;
    r.flash_address = addr;
    r.flash_data = data;
    r.last = lst;
    return r;
  endfunction

  // replace the words landing on the reset vector with a jump into the boot region
  function automatic logic [15:0] patch_word(input logic [15:0] addr, input logic [15:0] data);
    logic [15:0] half;
    half = boot_q >> 1;
    if (boot_q < RJMP_LIMIT) begin
      if (addr == VEC_ADDR) return RJMP_BASE + half - 16'd1;
    end else if (addr == VEC_ADDR) begin
      return JMP_OPCODE;
    end else if (addr == VEC_ADDR_NEXT) begin
      return half;
    end
    return data;
  endfunction

  task automatic step_sequencer(input item_t it);
    result_t     r[$];
    logic        leave;
    logic [15:0] wa;
    leave = 1'b0;
    if (it.op == OP_SETUP) begin
      idle_cnt[15:8] = 8'h00;
      if (it.request_code == REQ_INFO) begin
        r.push_back(beat(ACT_INFO, 16'h0, 16'h0, 1'b0));
      end else if (it.request_code == REQ_SET_ADDR) begin
        if (wr_addr != 16'h0) begin
          wr_addr = it.index_word & PAGE_MASK;
          r.push_back(beat(ACT_CLEAR, wr_addr, 16'h0, 1'b0));
        end
      end else if (it.request_code == REQ_DATA) begin
        r.push_back(beat(ACT_FILL, wr_addr, patch_word(wr_addr, it.value_word), 1'b0));
        wr_addr = wr_addr + 16'd2;
        r.push_back(beat(ACT_FILL, wr_addr, patch_word(wr_addr, it.index_word), 1'b0));
        wr_addr = wr_addr + 16'd2;
        if ((int'(wr_addr[7:0]) % PAGE_BYTES) == 0) pend_cmd = PEND_WRITE;
      end else begin
        pend_cmd = {1'b0, it.request_code[5:0]};
      end
    end else begin
      if (pend_cmd == PEND_ERASE) begin
        r.push_back(beat(ACT_ERASE, 16'h0, 16'h0, 1'b0));
        wr_addr = 16'h0;
      end
      if (pend_cmd == PEND_WRITE) begin
        wa = wr_addr - 16'd2;
        if (wa < boot_q) r.push_back(beat(ACT_WRITE, wa, 16'h0, 1'b0));
      end
      // a pending exit is not cleared by a tick; each timed-out tick leaves
      if (pend_cmd == PEND_EXIT) begin
        if (it.timed_out) leave = 1'b1;
      end else begin
        pend_cmd = PEND_NONE;
      end
      if (!leave) begin
        idle_cnt = idle_cnt + 16'd1;
        if (auto_q != 16'h0 && idle_cnt == auto_q && it.app_present) leave = 1'b1;
      end
      if (leave) r.push_back(beat(ACT_LEAVE, 16'h0, 16'h0, 1'b0));
    end
    if (r.size() == 0) r.push_back(beat(ACT_NONE, 16'h0, 16'h0, 1'b0));
    r[r.size() - 1].last = 1'b1;
    foreach (r[i]) owed_actions.push_back(r[i]);
  endtask

  always @(posedge clk) begin : monitor
    result_t w;
    item_t   it;
    int      n0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (owed_actions.size() == 0) begin
          report("beat with nothing owed, action", 16'(out_tuser), 16'h0);
        end else begin
          w = owed_actions.pop_front();
          if (out_tuser != w.action) report("action", 16'(out_tuser), 16'(w.action));
          if (out_tdata[15:0] != w.flash_address)
            report("flash_address", out_tdata[15:0], w.flash_address);
          if (out_tdata[31:16] != w.flash_data)
            report("flash_data", out_tdata[31:16], w.flash_data);
          if (out_tlast != w.last) report("last", 16'(out_tlast), 16'(w.last));
          act_seen[w.action]++;
        end
        checked++;
      end
      if (in_tvalid && in_tready) begin
        it = mk(in_tuser, in_tdata[7:0], in_tdata[23:8], in_tdata[39:24],
                in_tdata[40], in_tdata[41]);
        n0 = owed_actions.size();
        step_sequencer(it);
        if (pin_on) owed_actions[n0] = pin_beat;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BOOT_ADDR) boot_q = cfg_data;
        else auto_q = cfg_data;
      end
    end
  end

  task automatic send_item(input item_t it, input logic pin, input result_t want);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= {6'b0, it.app_present, it.timed_out, it.index_word, it.value_word,
                  it.request_code};
    pin_on    <= pin;
    pin_beat  <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send(input item_t it);
    send_item(it, 1'b0, '0);
  endtask

  // registers change only with nothing in flight; step the clock first so the
  // monitor has logged the last accepted beat
  task automatic write_reg(input logic idx, input logic [15:0] data);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (owed_actions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input item_t it, input logic pin, input result_t want);
    row_t r;
    r.it = it;
    r.pinned = pin;
    r.want = want;
    directed_rows.push_back(r);
  endtask

  function automatic logic rbit();
    return 1'($urandom);
  endfunction

  function automatic logic [15:0] r16();
    return 16'($urandom);
  endfunction

  task automatic random_burst();
    int          pick;
    int          nd;
    logic [15:0] base;
    pick = $urandom_range(99);
    if (pick < 55) begin
      // upload: erase or set a page, fill words, then poll
      if ($urandom_range(3) == 0) begin
        send(mk(OP_SETUP, REQ_ERASE, r16(), r16(), rbit(), rbit()));
        send(mk(OP_TICK, 8'($urandom), r16(), r16(), rbit(), rbit()));
      end else begin
        base = ($urandom_range(3) != 0) ? 16'($urandom_range(boot_q)) : r16();
        send(mk(OP_SETUP, REQ_SET_ADDR, r16(), base, rbit(), rbit()));
      end
      nd = ($urandom_range(2) == 0) ? 16 : $urandom_range(1, 16);
      repeat (nd) send(mk(OP_SETUP, REQ_DATA, r16(), r16(), rbit(), rbit()));
      repeat ($urandom_range(1, 2))
        send(mk(OP_TICK, 8'($urandom), r16(), r16(), $urandom_range(3) == 0, rbit()));
    end else if (pick < 70) begin
      send(mk(OP_SETUP, ($urandom_range(3) == 0) ? 8'h44 : REQ_EXIT, r16(), r16(),
              rbit(), rbit()));
      repeat ($urandom_range(1, 4)) send(mk(OP_TICK, 8'($urandom), r16(), r16(),
                                              rbit(), rbit()));
    end else if (pick < 80) begin
      // idle polls, to walk the auto-exit counter
      repeat ($urandom_range(1, 40))
        send(mk(OP_TICK, 8'($urandom), r16(), r16(), $urandom_range(7) == 0, rbit()));
    end else if (pick < 88) begin
      send(mk(OP_SETUP, 8'($urandom_range(0, 7)), r16(), r16(), rbit(), rbit()));
    end else begin
      send(mk(rbit(), 8'($urandom), r16(), r16(), rbit(), rbit()));
    end
  endtask

  initial begin : stimulus
    logic [15:0] boot_set[NUM_PHASES];
    logic [15:0] auto_set[NUM_PHASES];
    int          gap_of[4];
    int          stall_of[4];
    int          goal;
    boot_set = '{BOOT_ADDR_RST, 16'hFFFF, 16'h0000, 16'h2000, 16'h1FC0, 16'h0400,
                 16'h0000, 16'h1800};
    auto_set = '{AUTO_EXIT_RST, 16'hFFFF, 16'h0000, 16'd3, 16'd1, 16'd40, 16'd0, 16'd1200};
    boot_set[6] = 16'($urandom_range(255)) << 6;
    auto_set[6] = 16'($urandom_range(1, 300));
    gap_of   = '{0, 52, 0, 21};
    stall_of = '{0, 0, 52, 21};

    add_row(mk(OP_SETUP, REQ_INFO, 16'h0000, 16'h0000, 1'b0, 1'b0), 1'b1,
            beat(ACT_INFO, 16'h0000, 16'h0000, 1'b1));
    // address zero: set address is dropped
    add_row(mk(OP_SETUP, REQ_SET_ADDR, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1), 1'b1,
            beat(ACT_NONE, 16'h0000, 16'h0000, 1'b1));
    add_row(mk(OP_TICK, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0), 1'b1,
            beat(ACT_NONE, 16'h0000, 16'h0000, 1'b1));
    // reset vector becomes a relative jump to the boot region
    add_row(mk(OP_SETUP, REQ_DATA, 16'hFFFF, 16'h0000, 1'b0, 1'b0), 1'b1,
            beat(ACT_FILL, 16'h0000, 16'hCBFF, 1'b0));
    add_row(mk(OP_SETUP, REQ_SET_ADDR, 16'h0000, 16'hFFFF, 1'b0, 1'b0), 1'b1,
            beat(ACT_CLEAR, 16'hFFC0, 16'h0000, 1'b1));
    add_row(mk(OP_SETUP, REQ_DATA, 16'h1234, 16'hA5A5, 1'b0, 1'b0), 1'b0, '0);
    add_row(mk(OP_SETUP, REQ_SET_ADDR, 16'h0000, 16'h0041, 1'b0, 1'b0), 1'b0, '0);
    add_row(mk(OP_SETUP, REQ_ERASE, 16'h0000, 16'h0000, 1'b0, 1'b0), 1'b1,
            beat(ACT_NONE, 16'h0000, 16'h0000, 1'b1));
    add_row(mk(OP_TICK, 8'h00, 16'h0000, 16'h0000, 1'b1, 1'b1), 1'b1,
            beat(ACT_ERASE, 16'h0000, 16'h0000, 1'b1));
    add_row(mk(OP_SETUP, REQ_EXIT, 16'h0000, 16'h0000, 1'b0, 1'b0), 1'b0, '0);
    add_row(mk(OP_TICK, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b1), 1'b0, '0);
    add_row(mk(OP_TICK, 8'h00, 16'h0000, 16'h0000, 1'b1, 1'b0), 1'b1,
            beat(ACT_LEAVE, 16'h0000, 16'h0000, 1'b1));
    add_row(mk(OP_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1), 1'b0, '0);
    add_row(mk(OP_SETUP, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1), 1'b0, '0);
    add_row(mk(OP_TICK, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0), 1'b0, '0);
    // upper code bits are dropped: this one arms an erase
    add_row(mk(OP_SETUP, 8'h42, 16'h0000, 16'h0000, 1'b0, 1'b0), 1'b0, '0);
    add_row(mk(OP_TICK, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0), 1'b0, '0);
    add_row(mk(OP_SETUP, 8'h80, 16'h0000, 16'h0000, 1'b0, 1'b0), 1'b0, '0);
    add_row(mk(OP_TICK, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0), 1'b0, '0);
    add_row(mk(OP_SETUP, 8'h44, 16'h0000, 16'h0000, 1'b0, 1'b0), 1'b0, '0);
    add_row(mk(OP_TICK, 8'h00, 16'h0000, 16'h0000, 1'b1, 1'b0), 1'b0, '0);
    add_row(mk(OP_SETUP, REQ_DATA, 16'h0000, 16'hFFFF, 1'b0, 1'b0), 1'b0, '0);
    add_row(mk(OP_SETUP, 8'h83, 16'h0000, 16'h0000, 1'b0, 1'b0), 1'b0, '0);
    add_row(mk(OP_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0), 1'b0, '0);
    add_row(mk(OP_SETUP, REQ_SET_ADDR, 16'h0000, 16'h1800, 1'b0, 1'b0), 1'b0, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].it, directed_rows[i].pinned, directed_rows[i].want);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) begin
        write_reg(CFG_BOOT_ADDR, boot_set[ph]);
        write_reg(CFG_AUTO_EXIT, auto_set[ph]);
      end
      gap_pct = gap_of[ph % 4];
      stall_pct = stall_of[ph % 4];
      goal = sent + PHASE_ITEMS;
      while (sent < goal) random_burst();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (owed_actions.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    foreach (owed_actions[i]) report("missing beat, action", 16'h0, 16'(owed_actions[i].action));

    $display("%0d requests and ticks over %0d register settings, %0d result beats checked",
             sent, NUM_PHASES, checked);
    $display("fills %0d, page writes %0d, erases %0d, leaves %0d, clears %0d, mismatches %0d",
             act_seen[ACT_FILL], act_seen[ACT_WRITE], act_seen[ACT_ERASE],
             act_seen[ACT_LEAVE], act_seen[ACT_CLEAR], errors);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
